@@ sv/chunk_spill_reassembler_core_defines.svh @@
// ---------------------------------------------------------------------------
// chunk spill reassembler assertion macros
// shared concurrent assertion forms, sampled on clk, quiet while rst is high
// ---------------------------------------------------------------------------
`ifndef CHUNK_SPILL_REASSEMBLER_CORE_DEFINES_SVH
`define CHUNK_SPILL_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication
`define CSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/csr_pkg.sv @@
// ---------------------------------------------------------------------------
// csr_pkg
// types and constants shared by the chunk spill reassembler modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package csr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_W  = 10;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STRAY   = 3'd4;

  localparam logic [WORD_W-1:0] DELIM_WORD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] NONE_MARK  = 32'hFFFF_FFFF;
  // words of a rebuilt terminator chunk
  localparam logic [WORD_W-1:0] FILL_COUNT = 32'd2;
  localparam logic [WORD_W-1:0] FILL_WORD  = 32'd9999;

  localparam logic [CFG_W-1:0] MAX_CHUNKS_RESET = 10'd200;

  // results caused by one word; the second result's word is 9999 when it is
  // a payload (rebuilt terminator) and zero otherwise, the third is always zero
  typedef struct packed {
    logic [1:0]        cnt;
    logic [WORD_W-1:0] word0;
    logic [KIND_W-1:0] kind0;
    logic [KIND_W-1:0] kind1;
    logic [KIND_W-1:0] kind2;
  } entry_t;

  function automatic entry_t put_item(entry_t e, logic [WORD_W-1:0] wd,
                                      logic [KIND_W-1:0] kd);
    entry_t r;
    r = e;
    case (e.cnt)
      2'd0: begin
        r.word0 = wd;
        r.kind0 = kd;
        r.cnt   = 2'd1;
      end
      2'd1: begin
        r.kind1 = kd;
        r.cnt   = 2'd2;
      end
      2'd2: begin
        r.kind2 = kd;
        r.cnt   = 2'd3;
      end
      default: begin
        r = e;
      end
    endcase
    return r;
  endfunction

endpackage

@@ sv/csr_front.sv @@
// ---------------------------------------------------------------------------
// csr_front
// parses chunk words, tracks spill state, emits a bundle per word with results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [csr_pkg::CFG_W-1:0]   cfg_max_chunks,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [csr_pkg::WORD_W-1:0]  stream_word,
  input  logic                        host_end,
  output logic                        push,
  output csr_pkg::entry_t             push_data
);
  import csr_pkg::*;

  localparam int unsigned POS_W = 30;
  localparam logic [POS_W-1:0] POS_LENGTH  = 30'd0;
  localparam logic [POS_W-1:0] POS_TOTAL   = 30'd1;
  localparam logic [POS_W-1:0] POS_NUMBER  = 30'd2;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 30'd3;
  localparam logic [POS_W-1:0] LEN_FINAL   = 30'd5;

  logic [CFG_W-1:0]  max_chunks;
  logic [POS_W-1:0]  word_position, word_position_next;
  logic [POS_W-1:0]  chunk_length, chunk_length_next;
  logic [WORD_W-1:0] total_prev, total_prev_next;
  logic [WORD_W-1:0] total_now, total_now_next;
  logic [WORD_W-1:0] last_number, last_number_next;
  logic [WORD_W-1:0] chunks_seen, chunks_seen_next;
  logic              first_pass, first_pass_next;
  logic              skip_mode, skip_mode_next;
  logic              discard_mode, discard_mode_next;
  logic              host_start, host_start_next;
  entry_t            e;
  logic              accept;
  logic [WORD_W-1:0] max_wide;

  assign accept   = in_valid && in_ready;
  assign max_wide = {{(WORD_W-CFG_W){1'b0}}, max_chunks};

  always_comb begin
    logic [WORD_W-1:0] ln;
    logic [WORD_W-1:0] cs;
    logic              skip_fail;
    e                  = '0;
    ln                 = last_number;
    cs                 = chunks_seen;
    skip_fail          = 1'b0;
    word_position_next = word_position;
    chunk_length_next  = chunk_length;
    total_prev_next    = total_prev;
    total_now_next     = total_now;
    last_number_next   = last_number;
    chunks_seen_next   = chunks_seen;
    first_pass_next    = first_pass;
    skip_mode_next     = skip_mode;
    discard_mode_next  = discard_mode;
    host_start_next    = host_start;

    if (!discard_mode) begin
      if (word_position == POS_LENGTH) begin
        if (stream_word == DELIM_WORD) begin
          e = put_item(e, '0, KIND_STRAY);
          discard_mode_next = 1'b1;
          if (skip_mode) begin
            skip_mode_next  = 1'b0;
            first_pass_next = 1'b1;
          end
        end else begin
          chunk_length_next = stream_word[WORD_W-1:2];
          if (skip_mode && (stream_word[WORD_W-1:2] == '0)) begin
            e = put_item(e, '0, KIND_LOST);
            discard_mode_next = 1'b1;
            skip_mode_next    = 1'b0;
            first_pass_next   = 1'b1;
          end else begin
            word_position_next = POS_TOTAL;
          end
        end
      end else if (skip_mode) begin
        if (word_position == POS_TOTAL) begin
          total_now_next  = stream_word;
          total_prev_next = stream_word;
          host_start_next = 1'b0;
          if (host_start && (stream_word > max_wide)) begin
            e = put_item(e, '0, KIND_LOST);
            discard_mode_next = 1'b1;
            skip_fail         = 1'b1;
          end
        end
        if (!skip_fail) begin
          if (word_position >= chunk_length) begin
            word_position_next = POS_LENGTH;
            if (chunk_length == LEN_FINAL) begin
              skip_mode_next = 1'b0;
            end
          end else begin
            word_position_next = word_position + 30'd1;
          end
        end
      end else if (word_position == POS_TOTAL) begin
        total_now_next  = stream_word;
        host_start_next = 1'b0;
        if (host_start) begin
          total_prev_next = stream_word;
        end
        if (host_start && (stream_word > max_wide)) begin
          e = put_item(e, '0, KIND_LOST);
          discard_mode_next = 1'b1;
        end else begin
          word_position_next = POS_NUMBER;
        end
      end else if (word_position == POS_NUMBER) begin
        if (first_pass && (stream_word != '0)) begin
          // start-up: the spill is joined midway, skip to its final chunk
          if (chunk_length < POS_PAYLOAD) begin
            e = put_item(e, '0, KIND_LOST);
            discard_mode_next = 1'b1;
          end else begin
            first_pass_next    = 1'b0;
            skip_mode_next     = 1'b1;
            total_prev_next    = total_now;
            word_position_next = POS_PAYLOAD;
          end
        end else begin
          first_pass_next = 1'b0;
          if ((ln != NONE_MARK) && (stream_word != ln + 32'd1)) begin
            if ((ln + 32'd2 == total_prev) && (cs == total_prev - 32'd1)) begin
              // only the terminator chunk is missing: rebuild it
              e  = put_item(e, FILL_COUNT, KIND_PAYLOAD);
              e  = put_item(e, FILL_WORD, KIND_PAYLOAD);
              e  = put_item(e, '0, KIND_GOOD);
              cs = '0;
              ln = NONE_MARK;
            end else if (stream_word == '0) begin
              e  = put_item(e, '0, KIND_DROPPED);
              cs = '0;
              ln = NONE_MARK;
            end
          end
          total_prev_next  = total_now;
          last_number_next = ln;
          chunks_seen_next = cs;
          if ((total_now > max_wide) || (stream_word > total_now - 32'd1)) begin
            e = put_item(e, '0, KIND_LOST);
            discard_mode_next = 1'b1;
          end else begin
            last_number_next = stream_word;
            chunks_seen_next = cs + 32'd1;
            if (chunk_length < POS_PAYLOAD) begin
              e = put_item(e, '0, KIND_LOST);
              discard_mode_next = 1'b1;
            end else begin
              word_position_next = POS_PAYLOAD;
            end
          end
        end
      end else if (word_position < chunk_length) begin
        e = put_item(e, stream_word, KIND_PAYLOAD);
        word_position_next = word_position + 30'd1;
      end else begin
        // delimiter word
        if ((chunk_length == LEN_FINAL) && (last_number == total_prev - 32'd1)) begin
          e = put_item(e, '0, (chunks_seen != total_prev) ? KIND_DROPPED : KIND_GOOD);
          chunks_seen_next = '0;
          last_number_next = NONE_MARK;
        end
        word_position_next = POS_LENGTH;
      end
    end

    if (host_end) begin
      discard_mode_next  = 1'b0;
      word_position_next = POS_LENGTH;
      host_start_next    = 1'b1;
    end
  end

  assign push      = accept && (e.cnt != 2'd0);
  assign push_data = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunks    <= MAX_CHUNKS_RESET;
      word_position <= POS_LENGTH;
      chunk_length  <= '0;
      total_prev    <= '0;
      total_now     <= '0;
      last_number   <= NONE_MARK;
      chunks_seen   <= '0;
      first_pass    <= 1'b1;
      skip_mode     <= 1'b0;
      discard_mode  <= 1'b0;
      host_start    <= 1'b1;
    end else begin
      if (cfg_valid) begin
        max_chunks <= cfg_max_chunks;
      end
      if (accept) begin
        word_position <= word_position_next;
        chunk_length  <= chunk_length_next;
        total_prev    <= total_prev_next;
        total_now     <= total_now_next;
        last_number   <= last_number_next;
        chunks_seen   <= chunks_seen_next;
        first_pass    <= first_pass_next;
        skip_mode     <= skip_mode_next;
        discard_mode  <= discard_mode_next;
        host_start    <= host_start_next;
      end
    end
  end

endmodule

@@ sv/csr_queue.sv @@
// ---------------------------------------------------------------------------
// csr_queue
// short register queue of result bundles between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chunk_spill_reassembler_core_defines.svh"

module csr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csr_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output csr_pkg::entry_t pop_data,
  output logic            empty
);
  import csr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_ONE;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_ONE;
      end
      if (push && !pop) begin
        count <= count + CNT_ONE;
      end else if (pop && !push) begin
        count <= count - CNT_ONE;
      end
    end
  end

  `CSR_ASSERT_IMP(a_no_overflow, push, !full, "queue push while full")
  `CSR_ASSERT_IMP(a_no_underflow, pop, !empty, "queue pop while empty")
  `CSR_ASSERT_IMP(a_count_range, 1'b1, count <= CNT_FULL, "queue count beyond depth")

endmodule

@@ sv/csr_back.sv @@
// ---------------------------------------------------------------------------
// csr_back
// pops queue bundles and hands out their results one per cycle while out_ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chunk_spill_reassembler_core_defines.svh"

module csr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  csr_pkg::entry_t             q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csr_pkg::WORD_W-1:0]  out_word,
  output logic [csr_pkg::KIND_W-1:0]  item_kind,
  output logic                        run_last
);
  import csr_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;

  assign last      = (idx == cur.cnt - 2'd1);
  assign q_pop     = !q_empty && (!cur_valid || (out_ready && last));
  assign out_valid = cur_valid;
  assign run_last  = last;

  always_comb begin
    case (idx)
      2'd0: begin
        out_word  = cur.word0;
        item_kind = cur.kind0;
      end
      2'd1: begin
        out_word  = (cur.kind1 == KIND_PAYLOAD) ? FILL_WORD : '0;
        item_kind = cur.kind1;
      end
      default: begin
        out_word  = '0;
        item_kind = cur.kind2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_valid && out_ready) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  `CSR_ASSERT_NXT(a_bundle_cont, out_valid && out_ready && !run_last, out_valid, "bundle cut")
  `CSR_ASSERT_IMP(a_bundle_nonempty, cur_valid, cur.cnt != 2'd0, "empty bundle held")
  `CSR_ASSERT_IMP(a_index_in_bundle, cur_valid, idx < cur.cnt, "result index past bundle")

endmodule

@@ sv/chunk_spill_reassembler_core.sv @@
// ---------------------------------------------------------------------------
// chunk_spill_reassembler_core
// rebuilds spills from a chunked 32-bit readout stream
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  cfg      | cfg_valid / cfg_ready  | max_chunks
//  in       | in_valid / in_ready    | stream_word, host_end
//  out      | out_valid / out_ready  | out_word, item_kind, run_last
//
//  one stream word is taken every cycle while the result queue has room
//  a word gives zero to three results, handed out by the back end one per cycle while out_ready
//  the front-end word parser sets the input rate, the output stage the result rate
//  queue of QUEUE_DEPTH bundles lets either side stall without stopping the other until the queue fills or drains
//  rst is synchronous, one cycle; cfg_ready is always high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_spill_reassembler_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [csr_pkg::CFG_W-1:0]   max_chunks,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [csr_pkg::WORD_W-1:0]  stream_word,
  input  logic                        host_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csr_pkg::WORD_W-1:0]  out_word,
  output logic [csr_pkg::KIND_W-1:0]  item_kind,
  output logic                        run_last
);
  import csr_pkg::*;

  logic   q_push;
  entry_t q_push_data;
  logic   q_full;
  logic   q_pop;
  entry_t q_pop_data;
  logic   q_empty;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  csr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_max_chunks (max_chunks),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_word    (stream_word),
    .host_end       (host_end),
    .push           (q_push),
    .push_data      (q_push_data)
  );

  csr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  csr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .item_kind (item_kind),
    .run_last  (run_last)
  );

endmodule
